[hw/rtl/ulw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulw_pkg
// Types and reset constants shared by the UTF-8 line width meter.
// ----------------------------------------------------------------------------
package ulw_pkg;

   // Font metrics after reset, worked out at elaboration.
   localparam int unsigned RESET_FONT_SIZE = 16;
   localparam int unsigned RESET_NARROW    = (RESET_FONT_SIZE * 62 + 99) / 100;
   localparam int unsigned RESET_ASCENT    = (RESET_FONT_SIZE * 4 + 4) / 5;
   localparam int unsigned RESET_DESC_RAW  = RESET_FONT_SIZE - RESET_ASCENT;
   localparam int unsigned RESET_DESCENT   = (RESET_DESC_RAW < 1) ? 1 : RESET_DESC_RAW;
   localparam int unsigned RESET_BLEND     = (RESET_NARROW * 3 + RESET_FONT_SIZE * 2 + 4) / 5;
   localparam int unsigned RESET_OTHER     = (RESET_BLEND > RESET_NARROW) ?
                                             RESET_BLEND : RESET_NARROW;
   localparam int unsigned RESET_LINE_HT   = RESET_ASCENT + RESET_DESCENT;

   // Advances and vertical metrics derived from the font size.
   typedef struct packed {
      logic [15:0] narrow;
      logic [18:0] tab;
      logic [15:0] wide;
      logic [15:0] other;
      logic [15:0] ascent;
      logic [15:0] descent;
      logic [16:0] line_height;
   } font_metrics_type;

   // Stream state carried from one byte to the next.
   typedef struct packed {
      logic [31:0] width;
      logic [20:0] partial;
      logic [1:0]  seq_len;
      logic [1:0]  held;
      logic        finished;
   } stream_state_type;

   // One finished line as shown on the result channel.
   typedef struct packed {
      logic [31:0] line_width;
      logic [15:0] ascent;
      logic [15:0] descent;
      logic [16:0] line_height;
   } result_type;

endpackage

[hw/rtl/ulw_font_metrics.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulw_font_metrics
// Font size register and a short pipeline that derives the advances and the
// vertical metrics from it.
// ----------------------------------------------------------------------------
module ulw_font_metrics (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [15:0]               csr_write_data,
   output ulw_pkg::font_metrics_type metrics,
   output logic                      busy
);

   // Reciprocals for exact division by 100 and by 5 over the operand ranges.
   localparam logic [22:0] RECIP_100 = 23'd5368710;   // ceil(2^29 / 100)
   localparam logic [18:0] RECIP_5   = 19'd419431;    // ceil(2^21 / 5)
   localparam logic [1:0]  SETTLE_CYCLES = 2'd3;

   logic [15:0] font_ff,        font_in;
   logic [15:0] narrow_ff,      narrow_in;
   logic [15:0] ascent_ff,      ascent_in;
   logic [15:0] other_ff,       other_in;
   logic [15:0] descent_ff,     descent_in;
   logic [16:0] line_height_ff, line_height_in;
   logic [1:0]  busy_ff,        busy_in;

   logic [21:0] narrow_num;
   logic [44:0] narrow_prod;
   logic [18:0] ascent_num;
   logic [37:0] ascent_prod;
   logic [17:0] blend_num;
   logic [36:0] blend_prod;
   logic [15:0] blend;
   logic [15:0] desc_raw;

   always_comb begin
      font_in = csr_write_enable ? csr_write_data : font_ff;

      // First stage: narrow advance and ascent.
      narrow_num  = {font_ff, 6'b0} - {5'b0, font_ff, 1'b0} + 22'd99;
      narrow_prod = {23'b0, narrow_num} * {22'b0, RECIP_100};
      narrow_in   = narrow_prod[44:29];
      ascent_num  = {1'b0, font_ff, 2'b0} + 19'd4;
      ascent_prod = {19'b0, ascent_num} * {19'b0, RECIP_5};
      ascent_in   = ascent_prod[36:21];

      // Second stage: blended advance and descent.
      blend_num  = {2'b0, narrow_ff} + {1'b0, narrow_ff, 1'b0}
                 + {1'b0, font_ff, 1'b0} + 18'd4;
      blend_prod = {19'b0, blend_num} * {18'b0, RECIP_5};
      blend      = blend_prod[36:21];
      other_in   = (blend > narrow_ff) ? blend : narrow_ff;
      desc_raw   = font_ff - ascent_ff;
      if (font_ff == 16'd0) begin
         descent_in = 16'd0;
      end else if (desc_raw == 16'd0) begin
         descent_in = 16'd1;
      end else begin
         descent_in = desc_raw;
      end

      // Third stage: line height.
      line_height_in = (font_ff == 16'd0) ? 17'd0 : ({1'b0, ascent_ff} + {1'b0, descent_ff});

      if (csr_write_enable) begin
         busy_in = SETTLE_CYCLES;
      end else if (busy_ff != 2'd0) begin
         busy_in = busy_ff - 2'd1;
      end else begin
         busy_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         font_ff        <= 16'(ulw_pkg::RESET_FONT_SIZE);
         narrow_ff      <= 16'(ulw_pkg::RESET_NARROW);
         ascent_ff      <= 16'(ulw_pkg::RESET_ASCENT);
         other_ff       <= 16'(ulw_pkg::RESET_OTHER);
         descent_ff     <= 16'(ulw_pkg::RESET_DESCENT);
         line_height_ff <= 17'(ulw_pkg::RESET_LINE_HT);
         busy_ff        <= 2'd0;
      end else begin
         font_ff        <= font_in;
         narrow_ff      <= narrow_in;
         ascent_ff      <= ascent_in;
         other_ff       <= other_in;
         descent_ff     <= descent_in;
         line_height_ff <= line_height_in;
         busy_ff        <= busy_in;
      end
   end

   always_comb begin
      metrics.narrow      = narrow_ff;
      metrics.tab         = {narrow_ff, 3'b0};
      metrics.wide        = font_ff;
      metrics.other       = other_ff;
      metrics.ascent      = ascent_ff;
      metrics.descent     = descent_ff;
      metrics.line_height = line_height_ff;
      busy                = (busy_ff != 2'd0);
   end

endmodule

[hw/rtl/ulw_utf8_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulw_utf8_decode
// Decodes one byte against the open sequence, counts replacement characters,
// picks the advance of a finished code point and adds it all to the width.
// ----------------------------------------------------------------------------
module ulw_utf8_decode (
   input  ulw_pkg::stream_state_type cur,
   input  logic [7:0]                byte_value,
   input  logic                      last,
   input  ulw_pkg::font_metrics_type metrics,
   output ulw_pkg::stream_state_type nxt,
   output logic [31:0]               width_total
);

   localparam logic [20:0] CP_TAB        = 21'h00009;
   localparam logic [20:0] CP_LF         = 21'h0000A;
   localparam logic [20:0] CP_SPACE      = 21'h00020;
   localparam logic [20:0] CP_TILDE      = 21'h0007E;
   localparam logic [20:0] CP_BOM        = 21'h0FEFF;
   localparam logic [20:0] CP_MIN_2BYTE  = 21'h00080;
   localparam logic [20:0] CP_MIN_3BYTE  = 21'h00800;
   localparam logic [20:0] CP_MIN_4BYTE  = 21'h10000;
   localparam logic [20:0] CP_MAX        = 21'h10FFFF;
   localparam logic [20:0] CP_SURR_LO    = 21'h0D800;
   localparam logic [20:0] CP_SURR_HI    = 21'h0DFFF;
   localparam logic [20:0] JAMO_LO       = 21'h01100;
   localparam logic [20:0] JAMO_HI       = 21'h0115F;
   localparam logic [20:0] CJK_LO        = 21'h02E80;
   localparam logic [20:0] CJK_HI        = 21'h09FFF;
   localparam logic [20:0] HANGUL_LO     = 21'h0AC00;
   localparam logic [20:0] HANGUL_HI     = 21'h0D7A3;
   localparam logic [20:0] FULLWIDTH_LO  = 21'h0FF00;
   localparam logic [20:0] FULLWIDTH_HI  = 21'h0FFEF;

   logic [20:0] partial_next;
   logic [20:0] cp;
   logic        take_cp;
   logic        bad;
   logic [2:0]  repl_count;
   logic [18:0] repl_adv;
   logic [18:0] cp_adv;
   logic        is_wide;
   logic [33:0] sum;

   always_comb begin
      nxt          = cur;
      repl_count   = 3'd0;
      take_cp      = 1'b0;
      cp           = 21'd0;
      bad          = 1'b0;
      partial_next = {cur.partial[14:0], byte_value[5:0]};

      if (!cur.finished) begin
         if ((cur.seq_len != 2'd0) && (byte_value[7:6] == 2'b10)) begin
            if (cur.held < cur.seq_len) begin
               nxt.partial = partial_next;
               nxt.held    = cur.held + 2'd1;
            end else begin
               case (cur.seq_len)
                  2'd1:    bad = (partial_next < CP_MIN_2BYTE);
                  2'd2:    bad = (partial_next < CP_MIN_3BYTE)
                              || ((partial_next >= CP_SURR_LO) && (partial_next <= CP_SURR_HI));
                  default: bad = (partial_next < CP_MIN_4BYTE) || (partial_next > CP_MAX);
               endcase
               nxt.seq_len = 2'd0;
               nxt.held    = 2'd0;
               nxt.partial = 21'd0;
               if (bad) begin
                  // Every byte of the failed sequence, this one included.
                  repl_count = {1'b0, cur.held} + 3'd1;
               end else begin
                  take_cp = 1'b1;
                  cp      = partial_next;
               end
            end
         end else begin
            // A sequence broken by a non-continuation byte is flushed first.
            repl_count  = (cur.seq_len != 2'd0) ? {1'b0, cur.held} : 3'd0;
            nxt.seq_len = 2'd0;
            nxt.held    = 2'd0;
            nxt.partial = 21'd0;
            if (!byte_value[7]) begin
               take_cp = 1'b1;
               cp      = {13'd0, byte_value};
            end else if (byte_value[7:5] == 3'b110) begin
               nxt.seq_len = 2'd1;
               nxt.held    = 2'd1;
               nxt.partial = {16'd0, byte_value[4:0]};
            end else if (byte_value[7:4] == 4'b1110) begin
               nxt.seq_len = 2'd2;
               nxt.held    = 2'd1;
               nxt.partial = {17'd0, byte_value[3:0]};
            end else if (byte_value[7:3] == 5'b11110) begin
               nxt.seq_len = 2'd3;
               nxt.held    = 2'd1;
               nxt.partial = {18'd0, byte_value[2:0]};
            end else begin
               repl_count = repl_count + 3'd1;
            end
         end
      end

      // A sequence left open by the final byte is flushed as well.
      if (last && (nxt.seq_len != 2'd0)) begin
         repl_count = repl_count + {1'b0, nxt.held};
      end

      is_wide = ((cp >= JAMO_LO) && (cp <= JAMO_HI))
             || ((cp >= CJK_LO) && (cp <= CJK_HI))
             || ((cp >= HANGUL_LO) && (cp <= HANGUL_HI))
             || ((cp >= FULLWIDTH_LO) && (cp <= FULLWIDTH_HI));

      cp_adv = 19'd0;
      if (take_cp) begin
         if (cp == CP_LF) begin
            nxt.finished = 1'b1;
         end else if (cp == CP_TAB) begin
            cp_adv = metrics.tab;
         end else if ((cp < CP_SPACE) || (cp == CP_BOM)) begin
            cp_adv = 19'd0;
         end else if (cp <= CP_TILDE) begin
            cp_adv = {3'b0, metrics.narrow};
         end else if (is_wide) begin
            cp_adv = {3'b0, metrics.wide};
         end else begin
            cp_adv = {3'b0, metrics.other};
         end
      end

      // The replacement character takes the blended advance.
      case (repl_count)
         3'd1:    repl_adv = {3'b0, metrics.other};
         3'd2:    repl_adv = {2'b0, metrics.other, 1'b0};
         3'd3:    repl_adv = {2'b0, metrics.other, 1'b0} + {3'b0, metrics.other};
         3'd4:    repl_adv = {1'b0, metrics.other, 2'b0};
         default: repl_adv = 19'd0;
      endcase

      sum         = {2'b0, cur.width} + {15'b0, repl_adv} + {15'b0, cp_adv};
      width_total = (sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : sum[31:0];
      nxt.width   = width_total;

      if (last) begin
         nxt = '0;
      end
   end

endmodule

[hw/rtl/utf8_line_width_measure.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_line_width_measure
// Streaming width meter for one line of UTF-8 text with replacement of
// malformed sequences, reporting width and vertical font metrics.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle unless stalled; decode and width add are combinational.
// The last byte is registered, then its result is registered and raises rsp_valid.
// A write to font_size stalls input in its own cycle and while the metrics settle.
// A second result register takes one more line while the output is stalled.
// Synchronous reset clears the stream state and restores a font size of 16.
module utf8_line_width_measure (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_line_width,
   output logic [15:0] rsp_ascent,
   output logic [15:0] rsp_descent,
   output logic [16:0] rsp_line_height
);

   ulw_pkg::font_metrics_type metrics;
   ulw_pkg::stream_state_type state_ff, state_in, state_next;
   ulw_pkg::result_type       new_result;
   ulw_pkg::result_type       result_ff;
   ulw_pkg::result_type       skid_ff;
   logic        metrics_busy;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        skid_valid_ff, skid_valid_in;

   logic        hold_last;
   logic        advance;
   logic        accept;
   logic        out_load;
   logic        out_free;
   logic [31:0] width_total;

   ulw_font_metrics u_metrics (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .metrics          (metrics),
      .busy             (metrics_busy)
   );

   ulw_utf8_decode u_decode (
      .cur         (state_ff),
      .byte_value  (in_byte_ff),
      .last        (in_last_ff),
      .metrics     (metrics),
      .nxt         (state_next),
      .width_total (width_total)
   );

   always_comb begin
      // A final byte waits in the input register only while both result registers are full.
      hold_last     = in_valid_ff & in_last_ff & skid_valid_ff;
      advance       = in_valid_ff & ~hold_last;
      req_stall     = metrics_busy | csr_write_enable | hold_last;
      accept        = req_valid & ~req_stall;
      in_valid_in   = accept | hold_last;
      out_load      = advance & in_last_ff;
      out_free      = ~rsp_valid_ff | ~rsp_stall;
      rsp_valid_in  = out_free ? (skid_valid_ff | out_load) : 1'b1;
      skid_valid_in = ~out_free & (skid_valid_ff | out_load);
      state_in      = advance ? state_next : state_ff;

      new_result.line_width  = width_total;
      new_result.ascent      = metrics.ascent;
      new_result.descent     = metrics.descent;
      new_result.line_height = metrics.line_height;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         state_ff      <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
         state_ff      <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_byte_value;
         in_last_ff <= req_last;
      end
      if (out_free) begin
         if (skid_valid_ff) begin
            result_ff <= skid_ff;
         end else if (out_load) begin
            result_ff <= new_result;
         end
      end
      if (!out_free && out_load) begin
         skid_ff <= new_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_line_width  = result_ff.line_width;
   assign rsp_ascent      = result_ff.ascent;
   assign rsp_descent     = result_ff.descent;
   assign rsp_line_height = result_ff.line_height;

endmodule

[hw/rtl/ulw_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulw_checker
// Port-level checks on the line width meter, bound to the top level.
// ----------------------------------------------------------------------------
module ulw_checker (
   input logic        clock,
   input logic        reset,
   input logic        csr_write_enable,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_line_width,
   input logic [15:0] rsp_ascent,
   input logic [15:0] rsp_descent,
   input logic [16:0] rsp_line_height
);

   // No result survives a reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result keeps its width.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_line_width)))
      else $error("stalled result changed");

   // No byte transfer is taken alongside a font size write or straight after it.
   assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |-> req_stall)
      else $error("input taken during configuration write");

   assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> req_stall)
      else $error("input taken before metrics settled");

   // Line height is always the sum of ascent and descent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_height == ({1'b0, rsp_ascent} + {1'b0, rsp_descent})))
      else $error("line height mismatch");

endmodule

bind utf8_line_width_measure ulw_checker u_checker (.*);
